FILE: rtl/core/utf8v_pkg.sv
// Types, constants and a helper function shared by the UTF-8 text validator.
package utf8v_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LIMIT_W  = 12;
   localparam int unsigned CHARS_W  = 13;
   localparam int unsigned CODE_W   = 21;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd64;
   localparam logic [CHARS_W-1:0] CHARS_SAT   = 13'h1FFF;

   localparam logic [BYTE_W-1:0] ASCII_MAX   = 8'h7F;
   localparam logic [BYTE_W-1:0] LEAD2_LOW   = 8'hC2;
   localparam logic [BYTE_W-1:0] LEAD2_HIGH  = 8'hDF;
   localparam logic [BYTE_W-1:0] LEAD3_LOW   = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD3_HIGH  = 8'hEF;
   localparam logic [BYTE_W-1:0] LEAD4_LOW   = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD4_HIGH  = 8'hF4;

   localparam logic [CODE_W-1:0] CODE_MIN_2B = 21'h00080;
   localparam logic [CODE_W-1:0] CODE_MIN_3B = 21'h00800;
   localparam logic [CODE_W-1:0] CODE_MIN_4B = 21'h10000;
   localparam logic [CODE_W-1:0] CODE_MAX    = 21'h10FFFF;
   localparam logic [CODE_W-1:0] SURR_LOW    = 21'h0D800;
   localparam logic [CODE_W-1:0] SURR_HIGH   = 21'h0DFFF;

   typedef enum logic [1:0] {
      MIN_NONE,
      MIN_2B,
      MIN_3B,
      MIN_4B
   } min_class_type;

   typedef struct packed {
      logic [1:0]         pending;
      logic [CODE_W-1:0]  acc;
      min_class_type      min_class;
      logic [CHARS_W-1:0] chars;
      logic               failed;
   } text_state_type;

   function automatic logic [CODE_W-1:0] class_minimum(input min_class_type cls);
      logic [CODE_W-1:0] result;
      unique case (cls)
         MIN_2B:  result = CODE_MIN_2B;
         MIN_3B:  result = CODE_MIN_3B;
         MIN_4B:  result = CODE_MIN_4B;
         default: result = '0;
      endcase
      return result;
   endfunction

endpackage

FILE: rtl/core/utf8v_if.sv
// Handshake channel interfaces for the byte input, the result and the limit register.
interface utf8v_req_if
   import utf8v_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8v_rsp_if
   import utf8v_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               text_valid;
   logic [LIMIT_W-1:0] character_count;

   modport source (output valid, output text_valid, output character_count, input ready);
   modport sink   (input valid, input text_valid, input character_count, output ready);
endinterface

interface utf8v_csr_if
   import utf8v_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] max_characters;

   modport source (output valid, output max_characters, input ready);
   modport sink   (input valid, input max_characters, output ready);
endinterface

FILE: rtl/core/utf8v_step.sv
// Combinational decode of one byte against the running text state.
module utf8v_step
   import utf8v_pkg::*;
(
   input  text_state_type     state_cur,
   input  logic [BYTE_W-1:0]  data_byte,
   input  logic               last_byte,
   input  logic [LIMIT_W-1:0] max_characters,
   output text_state_type     state_next,
   output logic               text_valid,
   output logic [LIMIT_W-1:0] character_count
);

   text_state_type     upd;
   logic [CHARS_W-1:0] chars_inc;
   logic [CODE_W-1:0]  acc_shift;
   logic               inc_over;
   logic               code_bad;

   always_comb begin
      upd       = state_cur;
      chars_inc = (state_cur.chars == CHARS_SAT) ? state_cur.chars
                                                 : state_cur.chars + 13'd1;
      inc_over  = chars_inc > {1'b0, max_characters};
      acc_shift = {state_cur.acc[CODE_W-7:0], data_byte[5:0]};
      code_bad  = (acc_shift < class_minimum(state_cur.min_class)) ||
                  (acc_shift > CODE_MAX) ||
                  ((acc_shift >= SURR_LOW) && (acc_shift <= SURR_HIGH));

      if (!state_cur.failed) begin
         if (state_cur.pending == 2'd0) begin
            priority if (data_byte <= ASCII_MAX) begin
               upd.chars = chars_inc;
               if (inc_over) begin
                  upd.failed = 1'b1;
               end
            end else if (data_byte >= LEAD2_LOW && data_byte <= LEAD2_HIGH) begin
               upd.pending   = 2'd1;
               upd.min_class = MIN_2B;
               upd.acc       = {16'd0, data_byte[4:0]};
            end else if (data_byte >= LEAD3_LOW && data_byte <= LEAD3_HIGH) begin
               upd.pending   = 2'd2;
               upd.min_class = MIN_3B;
               upd.acc       = {17'd0, data_byte[3:0]};
            end else if (data_byte >= LEAD4_LOW && data_byte <= LEAD4_HIGH) begin
               upd.pending   = 2'd3;
               upd.min_class = MIN_4B;
               upd.acc       = {18'd0, data_byte[2:0]};
            end else begin
               upd.failed = 1'b1;
            end
         end else if (data_byte[7:6] != 2'b10) begin
            upd.failed = 1'b1;
         end else begin
            upd.acc     = acc_shift;
            upd.pending = state_cur.pending - 2'd1;
            if (state_cur.pending == 2'd1) begin
               if (code_bad) begin
                  upd.failed = 1'b1;
               end else begin
                  upd.chars = chars_inc;
                  if (inc_over) begin
                     upd.failed = 1'b1;
                  end
               end
               upd.acc       = '0;
               upd.min_class = MIN_NONE;
            end
         end
      end

      text_valid      = !upd.failed && (upd.pending == 2'd0) && (upd.chars != '0);
      character_count = text_valid ? upd.chars[LIMIT_W-1:0] : '0;
      state_next      = last_byte ? text_state_type'('0) : upd;
   end

endmodule

FILE: rtl/core/utf8_text_validator.sv
// Top level of the UTF-8 text validator: input register, decode step and result register.
// A text's result is registered from the decode step when its final byte item advances.
// Throughput: one byte item per cycle, but a final byte waits while a result is untaken.
// A waiting result does not stop bytes of the next text; only a second final byte waits.
// Reset is synchronous and active high; it clears the text state and sets the limit to 64.
module utf8_text_validator
   import utf8v_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   utf8v_req_if.sink   req_ch,
   utf8v_rsp_if.source rsp_ch,
   utf8v_csr_if.sink   csr_ch
);

   logic               in_valid_ff;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic               in_last_ff;
   text_state_type     state_ff;
   text_state_type     state_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic               out_valid_ff;
   logic               out_text_valid_ff;
   logic [LIMIT_W-1:0] out_count_ff;
   logic               step_valid;
   logic [LIMIT_W-1:0] step_count;
   logic               out_free;
   logic               advance;

   assign out_free      = !out_valid_ff || rsp_ch.ready;
   assign advance       = in_valid_ff && (!in_last_ff || out_free);
   assign req_ch.ready  = !in_valid_ff || advance;
   assign csr_ch.ready  = 1'b1;

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.text_valid      = out_text_valid_ff;
   assign rsp_ch.character_count = out_count_ff;

   utf8v_step u_step (
      .state_cur       (state_ff),
      .data_byte       (in_byte_ff),
      .last_byte       (in_last_ff),
      .max_characters  (limit_ff),
      .state_next      (state_in),
      .text_valid      (step_valid),
      .character_count (step_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance && in_last_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_ch.valid && csr_ch.ready) begin
            limit_ff <= csr_ch.max_characters;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.data_byte;
         in_last_ff <= req_ch.last_byte;
      end
      if (advance && in_last_ff) begin
         out_text_valid_ff <= step_valid;
         out_count_ff      <= step_count;
      end
   end

`ifndef SYNTHESIS
   a_result_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff && in_last_ff))
      else $error("A result appeared without a final byte item.");

   a_invalid_zero_count: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_text_valid_ff) |-> (out_count_ff == '0))
      else $error("An invalid text reported a non-zero character count.");

   a_cleared_after_final: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=>
      (state_ff.pending == 2'd0 && state_ff.chars == '0 && !state_ff.failed))
      else $error("Text state was not cleared after a final byte item.");

   a_pending_has_class: assert property (@(posedge clock) disable iff (reset)
      (state_ff.pending != 2'd0) |->
      (state_ff.min_class != MIN_NONE && 2'(state_ff.min_class) >= state_ff.pending))
      else $error("Pending continuation bytes exceed the sequence class.");
`endif

endmodule

FILE: verif/utf8_text_validator_test.sv
// Self-checking testbench for the UTF-8 text validator with a per-text character limit.
module utf8_text_validator_test import utf8v_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 6;
   localparam int REPORT_MAX     = 10;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              final_flag;
   } text_byte_type;

   typedef struct packed {
      logic               ok;
      logic [LIMIT_W-1:0] count;
   } verdict_type;

   logic clock;
   logic reset;

   utf8v_req_if req_ch ();
   utf8v_rsp_if rsp_ch ();
   utf8v_csr_if csr_ch ();

   utf8_text_validator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   text_byte_type     byte_queue[$];
   verdict_type       expected_verdicts[$];
   logic [BYTE_W-1:0] text_bytes[$];

   logic [1:0]         pend_cnt;
   logic [CODE_W-1:0]  code_acc;
   min_class_type      min_class;
   logic [CHARS_W-1:0] char_total;
   logic               text_bad;
   logic [LIMIT_W-1:0] limit_setting;

   bit          src_gaps;
   bit          rsp_stalls;
   int          hold_requests;
   int          hold_seen;
   int          hold_left;
   int          gap_left;
   int          burst_left;
   int          quiet_cycles;
   logic [15:0] stall_pattern;
   int          stall_step;

   int bytes_sent;
   int texts_checked;
   int valid_texts;
   int mismatches;
   int limits_written;

   always #6 clock = ~clock;

   task automatic tally_char();
      if (char_total != CHARS_SAT) begin
         char_total = char_total + 1'b1;
      end
      if (char_total > {1'b0, limit_setting}) begin
         text_bad = 1'b1;
      end
   endtask

   task automatic absorb_byte(input logic [BYTE_W-1:0] b, input logic final_flag);
      logic [CODE_W-1:0] cp_floor;
      verdict_type       v;
      if (!text_bad) begin
         if (pend_cnt == 2'd0) begin
            if (b <= ASCII_MAX) begin
               tally_char();
            end else if (b >= LEAD2_LOW && b <= LEAD2_HIGH) begin
               pend_cnt  = 2'd1;
               min_class = MIN_2B;
               code_acc  = CODE_W'(b[4:0]);
            end else if (b >= LEAD3_LOW && b <= LEAD3_HIGH) begin
               pend_cnt  = 2'd2;
               min_class = MIN_3B;
               code_acc  = CODE_W'(b[3:0]);
            end else if (b >= LEAD4_LOW && b <= LEAD4_HIGH) begin
               pend_cnt  = 2'd3;
               min_class = MIN_4B;
               code_acc  = CODE_W'(b[2:0]);
            end else begin
               text_bad = 1'b1;
            end
         end else if (b[7:6] != 2'b10) begin
            text_bad = 1'b1;
         end else begin
            code_acc = {code_acc[CODE_W-7:0], b[5:0]};
            pend_cnt = pend_cnt - 2'd1;
            if (pend_cnt == 2'd0) begin
               case (min_class)
                  MIN_2B:  cp_floor = CODE_MIN_2B;
                  MIN_3B:  cp_floor = CODE_MIN_3B;
                  MIN_4B:  cp_floor = CODE_MIN_4B;
                  default: cp_floor = '0;
               endcase
               if (code_acc < cp_floor || code_acc > CODE_MAX ||
                   (code_acc >= SURR_LOW && code_acc <= SURR_HIGH)) begin
                  text_bad = 1'b1;
               end else begin
                  tally_char();
               end
               code_acc  = '0;
               min_class = MIN_NONE;
            end
         end
      end
      if (final_flag) begin
         v.ok    = !text_bad && pend_cnt == 2'd0 && char_total != '0;
         v.count = v.ok ? char_total[LIMIT_W-1:0] : '0;
         expected_verdicts.push_back(v);
         pend_cnt   = 2'd0;
         code_acc   = '0;
         min_class  = MIN_NONE;
         char_total = '0;
         text_bad   = 1'b0;
      end
   endtask

   function automatic int unsigned pick_code();
      int unsigned cp;
      int unsigned edges [10] = '{'h0, 'h7F, 'h80, 'h7FF, 'h800, 'hD7FF, 'hE000, 'hFFFF,
                                  'h10000, 'h10FFFF};
      case ($urandom_range(0, 4))
         0: cp = $urandom_range(0, 'h7F);
         1: cp = $urandom_range('h80, 'h7FF);
         2: begin
            cp = $urandom_range('h800, 'hF7FF);
            if (cp >= 'hD800) begin
               cp = cp + 'h800;
            end
         end
         3: cp = $urandom_range('h10000, 'h10FFFF);
         default: cp = edges[$urandom_range(0, 9)];
      endcase
      return cp;
   endfunction

   task automatic add_code(input int unsigned cp);
      if (cp < 'h80) begin
         text_bytes.push_back(8'(cp));
      end else if (cp < 'h800) begin
         text_bytes.push_back(8'hC0 | 8'(cp >> 6));
         text_bytes.push_back(8'h80 | 8'(cp & 'h3F));
      end else if (cp < 'h10000) begin
         text_bytes.push_back(8'hE0 | 8'(cp >> 12));
         text_bytes.push_back(8'h80 | 8'((cp >> 6) & 'h3F));
         text_bytes.push_back(8'h80 | 8'(cp & 'h3F));
      end else begin
         text_bytes.push_back(8'hF0 | 8'(cp >> 18));
         text_bytes.push_back(8'h80 | 8'((cp >> 12) & 'h3F));
         text_bytes.push_back(8'h80 | 8'((cp >> 6) & 'h3F));
         text_bytes.push_back(8'h80 | 8'(cp & 'h3F));
      end
   endtask

   function automatic int queue_text();
      text_byte_type item;
      foreach (text_bytes[i]) begin
         item.data       = text_bytes[i];
         item.final_flag = (i == text_bytes.size() - 1);
         byte_queue.push_back(item);
      end
      return text_bytes.size();
   endfunction

   task automatic make_text(input int unsigned n_chars, input bit broken, output int len);
      logic [BYTE_W-1:0] bad_seq[$];
      int                pos;
      int                keep;
      text_bytes.delete();
      repeat (n_chars) add_code(pick_code());
      if (broken) begin
         case ($urandom_range(0, 3))
            0: text_bytes[$urandom_range(0, text_bytes.size() - 1)] =
                  8'($urandom_range(0, 255));
            1: begin
               keep = $urandom_range(1, text_bytes.size());
               while (text_bytes.size() > keep) begin
                  void'(text_bytes.pop_back());
               end
            end
            2: begin
               case ($urandom_range(0, 6))
                  0: bad_seq = '{8'($urandom_range('hC0, 'hC1)), 8'($urandom_range('h80, 'hBF))};
                  1: bad_seq = '{8'hE0, 8'($urandom_range('h80, 'h9F)),
                                 8'($urandom_range('h80, 'hBF))};
                  2: bad_seq = '{8'hF0, 8'($urandom_range('h80, 'h8F)),
                                 8'($urandom_range('h80, 'hBF)), 8'($urandom_range('h80, 'hBF))};
                  3: bad_seq = '{8'hED, 8'($urandom_range('hA0, 'hBF)),
                                 8'($urandom_range('h80, 'hBF))};
                  4: bad_seq = '{8'hF4, 8'($urandom_range('h90, 'hBF)),
                                 8'($urandom_range('h80, 'hBF)), 8'($urandom_range('h80, 'hBF))};
                  5: bad_seq = '{8'($urandom_range('hF5, 'hFF))};
                  default: bad_seq = '{8'($urandom_range('h80, 'hBF))};
               endcase
               pos = $urandom_range(0, text_bytes.size());
               foreach (bad_seq[i]) begin
                  text_bytes.insert(pos + i, bad_seq[i]);
               end
            end
            default: begin
               text_bytes.delete();
               repeat ($urandom_range(1, 8)) text_bytes.push_back(8'($urandom_range(0, 255)));
            end
         endcase
      end
      len = queue_text();
   endtask

   task automatic random_texts(input int budget);
      int          made;
      int          len;
      int unsigned cap;
      int unsigned n;
      made = 0;
      cap  = (limit_setting < 10) ? limit_setting + 1 : 10;
      while (made < budget) begin
         case ($urandom_range(0, 9))
            0: n = (limit_setting <= 80) ? limit_setting : $urandom_range(1, cap);
            1: n = (limit_setting <= 80) ? limit_setting + 1 : $urandom_range(1, cap);
            default: n = $urandom_range(1, cap);
         endcase
         make_text(n, $urandom_range(0, 3) == 0, len);
         made = made + len;
      end
   endtask

   task automatic settle();
      while (byte_queue.size() != 0 || req_ch.valid || expected_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      csr_ch.max_characters <= value;
      csr_ch.valid          <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      limit_setting = value;
      limits_written++;
      csr_ch.valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      logic offer;
      offer = 1'b0;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            absorb_byte(req_ch.data_byte, req_ch.last_byte);
            void'(byte_queue.pop_front());
            bytes_sent++;
         end
         if (req_ch.valid && !req_ch.ready) begin
            offer = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (byte_queue.size() != 0) begin
            offer = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = src_gaps ? $urandom_range(1, 8) : 0;
            end
         end
         req_ch.valid <= offer;
         if (offer) begin
            req_ch.data_byte <= byte_queue[0].data;
            req_ch.last_byte <= byte_queue[0].final_flag;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_seen != hold_requests) begin
         hold_seen     = hold_requests;
         hold_left     = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!rsp_stalls) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= stall_pattern[stall_step];
         stall_step = (stall_step + 1) % 16;
         if (stall_step == 0) begin
            stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                       : 16'($urandom_range(1, 'hFFFF));
         end
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         texts_checked++;
         if (expected_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("%0t: result with no text outstanding: text_valid=%0b count=%0d",
                        $realtime, rsp_ch.text_valid, rsp_ch.character_count);
            end
         end else begin
            want = expected_verdicts.pop_front();
            if (want.ok) begin
               valid_texts++;
            end
            if (rsp_ch.text_valid !== want.ok || rsp_ch.character_count !== want.count) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display({"%0t: verdict mismatch: expected valid=%0b count=%0d, ",
                            "got valid=%0b count=%0d"},
                           $realtime, want.ok, want.count, rsp_ch.text_valid,
                           rsp_ch.character_count);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, no item moved for %0d cycles, %0d results outstanding",
                  $realtime, quiet_cycles, expected_verdicts.size());
         $display("** utf8_text_validator: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.data_byte      = '0;
      req_ch.last_byte      = 1'b0;
      rsp_ch.ready          = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.max_characters = LIMIT_RESET;
      limit_setting         = LIMIT_RESET;
      pend_cnt              = 2'd0;
      code_acc              = '0;
      min_class             = MIN_NONE;
      char_total            = '0;
      text_bad              = 1'b0;
      src_gaps              = 1'b1;
      rsp_stalls            = 1'b1;
      hold_requests         = 0;
      hold_seen             = 0;
      hold_left             = 0;
      gap_left              = 0;
      burst_left            = 1;
      quiet_cycles          = 0;
      stall_pattern         = 16'hA5F3;
      stall_step            = 0;
      bytes_sent            = 0;
      texts_checked         = 0;
      valid_texts           = 0;
      mismatches            = 0;
      limits_written        = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      text_bytes = '{8'h00};
      void'(queue_text());
      text_bytes = '{8'h7F, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
      void'(queue_text());
      text_bytes = '{8'hE0, 8'h80, 8'h80};
      void'(queue_text());
      text_bytes = '{8'hED, 8'hA0, 8'h80};
      void'(queue_text());
      text_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
      void'(queue_text());
      text_bytes = '{8'hC0, 8'h41};
      void'(queue_text());
      text_bytes = '{8'hC2};
      void'(queue_text());
      text_bytes = '{8'hC2, 8'h41};
      void'(queue_text());
      random_texts(200);
      settle();

      write_limit(12'd1);
      src_gaps   = 1'b0;
      rsp_stalls = 1'b0;
      random_texts(150);
      settle();

      write_limit(12'd4095);
      src_gaps   = 1'b1;
      rsp_stalls = 1'b1;
      random_texts(100);
      settle();

      write_limit(12'd3);
      src_gaps = 1'b0;
      hold_requests++;
      random_texts(250);
      settle();

      write_limit(LIMIT_W'($urandom_range(4, 4095)));
      src_gaps = 1'b1;
      random_texts(200);
      settle();

      write_limit(12'd2);
      rsp_stalls = 1'b0;
      random_texts(200);
      settle();

      write_limit(12'd64);
      rsp_stalls = 1'b1;
      random_texts(350);
      settle();

      $display("Checked %0d texts (%0d valid, %0d rejected) from %0d bytes.",
               texts_checked, valid_texts, texts_checked - valid_texts, bytes_sent);
      $display("Stimulus mixed well-formed UTF-8, malformed sequences, noise and %0d limits.",
               limits_written);
      if (mismatches == 0) begin
         $display("** utf8_text_validator: PASSED **");
      end else begin
         $display("** utf8_text_validator: FAILED **");
      end
      $finish;
   end

endmodule
